/* design/lcpd_pkg.sv */
// ---------------------------------------------------------------------------
// lcpd_pkg
// Shared types and constants for the line centroid PID drive block.
// ---------------------------------------------------------------------------
package lcpd_pkg;

  localparam int SENSOR_COUNT   = 8;
  localparam int STEP_UNITS     = 100;
  localparam int FULL_SCALE     = (SENSOR_COUNT - 1) * STEP_UNITS;
  localparam int SNAP_MARGIN    = 50;
  localparam int PWM_PERIOD     = 100;

  localparam int POS_BITS       = 10;
  localparam int BASE_BITS      = 7;
  localparam int GAIN_BITS      = 8;
  localparam int MAG_BITS       = 7;
  localparam int ERR_BITS       = 11;
  localparam int DIFF_BITS      = 12;
  localparam int ACTION_BITS    = 2;
  localparam int CFG_BITS       = 10;
  localparam int CFG_INDEX_BITS = 3;

  localparam int COUNT_BITS     = $clog2(SENSOR_COUNT + 1);
  localparam int WSUM_BITS      =
    $clog2(STEP_UNITS * SENSOR_COUNT * (SENSOR_COUNT - 1) / 2 + 1);

  localparam int OUT_BITS       = POS_BITS + 1 + SENSOR_COUNT + 2 * (MAG_BITS + 1);
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [POS_BITS-1:0]  TARGET_RESET = POS_BITS'(350);
  localparam logic [BASE_BITS-1:0] BASE_RESET   = BASE_BITS'(20);

  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BASE   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KP     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KD     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_KI     = 3'd4;

  localparam logic [ACTION_BITS-1:0] ACT_LINE = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_BG   = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_RUN  = 2'd2;

  typedef struct packed {
    logic                    valid;
    logic [POS_BITS-1:0]     position;
    logic                    line_seen;
    logic [SENSOR_COUNT-1:0] sensor_bits;
  } lcpd_pos_t;

  typedef struct packed {
    logic                    valid;
    logic [POS_BITS-1:0]     position;
    logic                    line_seen;
    logic [SENSOR_COUNT-1:0] sensor_bits;
    logic [MAG_BITS-1:0]     left_magnitude;
    logic                    left_reverse;
    logic [MAG_BITS-1:0]     right_magnitude;
    logic                    right_reverse;
  } lcpd_result_t;

endpackage

/* design/line_centroid_pid_drive.sv */
// ---------------------------------------------------------------------------
// line_centroid_pid_drive
// Line sensor front end: per-channel thresholds, centroid position and
// PID steering of two drives.
// ---------------------------------------------------------------------------
// One request at a time. Calibration requests (capture line, capture
// background) finish in the cycle they are accepted and give no result. A
// run request raises m_tvalid once its result is through the steps below.
// The lane compare is taken at acceptance. After that come the hit count
// and weighted sum, the two-bit-per-cycle centroid divide (skipped when
// nothing is marked) and the PID sequence on its single shared multiplier.
// s_tready returns in the cycle after the result is loaded, so a request
// is not taken while an earlier run is still in progress. A result held by
// the receiver stalls the next run at its last PID step. A new request is
// taken while the previous result still waits in the output register.
module line_centroid_pid_drive #(
  parameter int SAMPLE_BITS   = 12,
  parameter int HISTORY_DEPTH = 6
) (
  input  logic                                       clk,
  input  logic                                       rst,
  // samples 0 to SENSOR_COUNT-1, sample_0 lowest
  input  logic [((lcpd_pkg::SENSOR_COUNT*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // action
  input  logic [lcpd_pkg::ACTION_BITS-1:0]           s_tuser,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // position, line_seen, sensor_bits, left_magnitude, left_reverse,
  // right_magnitude, right_reverse
  output logic [lcpd_pkg::OUT_TDATA_BITS-1:0]        m_tdata,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  input  logic                                       cfg_we,
  input  logic [lcpd_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [lcpd_pkg::CFG_BITS-1:0]              cfg_wdata
);
  import lcpd_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                    state;
  logic                    accept;
  logic                    out_free;
  logic [POS_BITS-1:0]     target;
  logic [BASE_BITS-1:0]    base;
  logic [GAIN_BITS-1:0]    kp;
  logic [GAIN_BITS-1:0]    kd;
  logic [GAIN_BITS-1:0]    ki;
  logic [SENSOR_COUNT-1:0] hits;
  lcpd_pos_t               pos;
  lcpd_result_t            res;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
    lcpd_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk          (clk),
      .rst          (rst),
      .capture_line (accept && (s_tuser == ACT_LINE)),
      .capture_bg   (accept && (s_tuser == ACT_BG)),
      .sample       (s_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]),
      .hit          (hits[i])
    );
  end

  lcpd_merge u_merge (
    .clk   (clk),
    .rst   (rst),
    .start (accept && (s_tuser == ACT_RUN)),
    .bits  (hits),
    .pos   (pos)
  );

  lcpd_pid #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_pid (
    .clk      (clk),
    .rst      (rst),
    .pos      (pos),
    .target   (target),
    .base     (base),
    .kp       (kp),
    .kd       (kd),
    .ki       (ki),
    .out_free (out_free),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= TARGET_RESET;
      base   <= BASE_RESET;
      kp     <= '0;
      kd     <= '0;
      ki     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET: target <= cfg_wdata[POS_BITS-1:0];
        REG_BASE:   base   <= cfg_wdata[BASE_BITS-1:0];
        REG_KP:     kp     <= cfg_wdata[GAIN_BITS-1:0];
        REG_KD:     kd     <= cfg_wdata[GAIN_BITS-1:0];
        REG_KI:     ki     <= cfg_wdata[GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && (s_tuser == ACT_RUN)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (res.valid) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= OUT_TDATA_BITS'({res.right_reverse, res.right_magnitude,
                                  res.left_reverse, res.left_magnitude,
                                  res.sensor_bits, res.line_seen, res.position});
    end
  end

endmodule

/* design/lcpd_lane.sv */
// ---------------------------------------------------------------------------
// lcpd_lane
// One sensor channel: stored line level, threshold and the compare.
// ---------------------------------------------------------------------------
module lcpd_lane #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   capture_line,
  input  logic                   capture_bg,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   hit
);

  logic [SAMPLE_BITS-1:0] line_level;
  logic [SAMPLE_BITS-1:0] threshold;
  logic [SAMPLE_BITS:0]   level_sum;

  assign level_sum = {1'b0, line_level} + {1'b0, sample};
  assign hit       = (sample >= threshold);

  always_ff @(posedge clk) begin
    if (capture_line) begin
      line_level <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (capture_bg) begin
      threshold <= level_sum[SAMPLE_BITS:1];
    end
  end

endmodule

/* design/lcpd_merge.sv */
// ---------------------------------------------------------------------------
// lcpd_merge
// Combines lane hits into a centroid: count, weighted sum, radix-4 divide.
// ---------------------------------------------------------------------------
module lcpd_merge (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [lcpd_pkg::SENSOR_COUNT-1:0] bits,
  output lcpd_pkg::lcpd_pos_t              pos
);
  import lcpd_pkg::*;

  localparam int DIV_STEPS = (WSUM_BITS + 1) / 2;
  localparam int DIV_BITS  = 2 * DIV_STEPS;
  localparam int STEP_BITS = $clog2(DIV_STEPS);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_SUM  = 2'd1;
  localparam logic [1:0] M_DIV  = 2'd2;

  logic [1:0]              mstate;
  logic [SENSOR_COUNT-1:0] bits_r;
  logic [COUNT_BITS-1:0]   count_r;
  logic [COUNT_BITS-1:0]   rem;
  logic [DIV_BITS-1:0]     quo;
  logic [DIV_BITS-1:0]     quo_next;
  logic [STEP_BITS-1:0]    step;
  logic [POS_BITS-1:0]     last_pos;

  logic [COUNT_BITS-1:0]   count_c;
  logic [WSUM_BITS-1:0]    wsum_c;
  logic [POS_BITS-1:0]     snap_c;
  logic [COUNT_BITS:0]     rem1;
  logic [COUNT_BITS:0]     r1;
  logic [COUNT_BITS:0]     rem2;
  logic [COUNT_BITS:0]     r2;
  logic                    q1;
  logic                    q2;

  always_comb begin
    count_c = '0;
    wsum_c  = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (bits_r[i]) begin
        count_c = count_c + COUNT_BITS'(1);
        wsum_c  = wsum_c + WSUM_BITS'(i * STEP_UNITS);
      end
    end
  end

  always_comb begin
    if (last_pos <= POS_BITS'(SNAP_MARGIN)) begin
      snap_c = '0;
    end else if (last_pos >= POS_BITS'(FULL_SCALE - SNAP_MARGIN)) begin
      snap_c = POS_BITS'(FULL_SCALE);
    end else begin
      snap_c = last_pos;
    end
  end

  // two restoring steps per cycle
  always_comb begin
    rem1 = {rem, quo[DIV_BITS-1]};
    if (rem1 >= {1'b0, count_r}) begin
      r1 = rem1 - {1'b0, count_r};
      q1 = 1'b1;
    end else begin
      r1 = rem1;
      q1 = 1'b0;
    end
    rem2 = {r1[COUNT_BITS-1:0], quo[DIV_BITS-2]};
    if (rem2 >= {1'b0, count_r}) begin
      r2 = rem2 - {1'b0, count_r};
      q2 = 1'b1;
    end else begin
      r2 = rem2;
      q2 = 1'b0;
    end
    quo_next = {quo[DIV_BITS-3:0], q1, q2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate    <= M_IDLE;
      last_pos  <= '0;
      pos.valid <= 1'b0;
    end else begin
      pos.valid <= 1'b0;
      unique case (mstate)
        M_IDLE: begin
          if (start) begin
            bits_r <= bits;
            mstate <= M_SUM;
          end
        end
        M_SUM: begin
          count_r         <= count_c;
          quo             <= DIV_BITS'(wsum_c);
          rem             <= '0;
          step            <= '0;
          pos.sensor_bits <= bits_r;
          pos.line_seen   <= (count_c != '0);
          if (count_c == '0) begin
            pos.valid    <= 1'b1;
            pos.position <= snap_c;
            last_pos     <= snap_c;
            mstate       <= M_IDLE;
          end else begin
            mstate <= M_DIV;
          end
        end
        M_DIV: begin
          rem  <= r2[COUNT_BITS-1:0];
          quo  <= quo_next;
          step <= step + STEP_BITS'(1);
          if (step == STEP_BITS'(DIV_STEPS - 1)) begin
            pos.valid    <= 1'b1;
            pos.position <= quo_next[POS_BITS-1:0];
            last_pos     <= quo_next[POS_BITS-1:0];
            mstate       <= M_IDLE;
          end
        end
        default: begin
          mstate <= M_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/lcpd_pid.sv */
// ---------------------------------------------------------------------------
// lcpd_pid
// PID term on one shared multiplier, error history and the two drives.
// ---------------------------------------------------------------------------
module lcpd_pid #(
  parameter int HISTORY_DEPTH = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lcpd_pkg::lcpd_pos_t               pos,
  input  logic [lcpd_pkg::POS_BITS-1:0]     target,
  input  logic [lcpd_pkg::BASE_BITS-1:0]    base,
  input  logic [lcpd_pkg::GAIN_BITS-1:0]    kp,
  input  logic [lcpd_pkg::GAIN_BITS-1:0]    kd,
  input  logic [lcpd_pkg::GAIN_BITS-1:0]    ki,
  input  logic                              out_free,
  output lcpd_pkg::lcpd_result_t            res
);
  import lcpd_pkg::*;

  localparam int HSUM_BITS  = ERR_BITS + $clog2(HISTORY_DEPTH);
  localparam int OP_BITS    = (HSUM_BITS > DIFF_BITS) ? HSUM_BITS : DIFF_BITS;
  localparam int PROD_BITS  = OP_BITS + GAIN_BITS + 1;
  localparam int TERM_BITS  = PROD_BITS + 2;
  localparam int DRIVE_BITS = TERM_BITS + 1;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_MULP = 3'd1;
  localparam logic [2:0] P_MULD = 3'd2;
  localparam logic [2:0] P_MULI = 3'd3;
  localparam logic [2:0] P_ACC  = 3'd4;
  localparam logic [2:0] P_SUM  = 3'd5;
  localparam logic [2:0] P_OUT  = 3'd6;

  logic [2:0]                   phase;
  lcpd_pos_t                    pos_r;
  logic signed [ERR_BITS-1:0]   err_r;
  logic signed [DIFF_BITS-1:0]  diff_r;
  logic signed [ERR_BITS-1:0]   hist [HISTORY_DEPTH];
  logic signed [HSUM_BITS-1:0]  hsum;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [TERM_BITS-1:0]  acc;
  logic signed [DRIVE_BITS-1:0] left;
  logic signed [DRIVE_BITS-1:0] right;

  logic signed [ERR_BITS-1:0]   err_c;
  logic signed [DIFF_BITS-1:0]  diff_c;
  logic signed [GAIN_BITS:0]    gain_c;
  logic signed [OP_BITS-1:0]    op_c;
  logic signed [HSUM_BITS+1:0]  hsum_c;
  logic signed [DRIVE_BITS-1:0] base_c;

  function automatic logic [MAG_BITS:0] drive_mag(input logic signed [DRIVE_BITS-1:0] d);
    logic [DRIVE_BITS-1:0] m;
    logic [MAG_BITS-1:0]   sat;
    m = d[DRIVE_BITS-1] ? DRIVE_BITS'(-d) : DRIVE_BITS'(d);
    if (m > DRIVE_BITS'(PWM_PERIOD)) begin
      sat = MAG_BITS'(PWM_PERIOD);
    end else begin
      sat = m[MAG_BITS-1:0];
    end
    return {sat, d[DRIVE_BITS-1]};
  endfunction

  assign err_c  = signed'({1'b0, pos.position}) - signed'({1'b0, target});
  assign diff_c = DIFF_BITS'(err_c) - DIFF_BITS'(hist[0]);
  assign hsum_c = (HSUM_BITS+2)'(hsum) + (HSUM_BITS+2)'(err_r)
                - (HSUM_BITS+2)'(hist[HISTORY_DEPTH-1]);
  assign base_c = signed'(DRIVE_BITS'(base));

  always_comb begin
    case (phase)
      P_MULD: begin
        gain_c = signed'({1'b0, kd});
        op_c   = OP_BITS'(diff_r);
      end
      P_MULI: begin
        gain_c = signed'({1'b0, ki});
        op_c   = OP_BITS'(hsum);
      end
      default: begin
        gain_c = signed'({1'b0, kp});
        op_c   = OP_BITS'(err_r);
      end
    endcase
  end

  always_comb begin
    res.valid       = (phase == P_OUT) && out_free;
    res.position    = pos_r.position;
    res.line_seen   = pos_r.line_seen;
    res.sensor_bits = pos_r.sensor_bits;
    {res.left_magnitude, res.left_reverse}   = drive_mag(left);
    {res.right_magnitude, res.right_reverse} = drive_mag(right);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      hsum  <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= '0;
      end
    end else begin
      unique case (phase)
        P_IDLE: begin
          if (pos.valid) begin
            pos_r  <= pos;
            err_r  <= err_c;
            diff_r <= diff_c;
            acc    <= '0;
            phase  <= P_MULP;
          end
        end
        P_MULP: begin
          prod  <= gain_c * op_c;
          phase <= P_MULD;
        end
        P_MULD: begin
          acc   <= acc + TERM_BITS'(prod);
          prod  <= gain_c * op_c;
          phase <= P_MULI;
        end
        P_MULI: begin
          acc   <= acc + TERM_BITS'(prod);
          prod  <= gain_c * op_c;
          phase <= P_ACC;
        end
        P_ACC: begin
          acc   <= acc + TERM_BITS'(prod);
          phase <= P_SUM;
        end
        P_SUM: begin
          left  <= base_c + DRIVE_BITS'(acc);
          right <= base_c - DRIVE_BITS'(acc);
          phase <= P_OUT;
        end
        P_OUT: begin
          if (out_free) begin
            for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
              hist[i] <= hist[i-1];
            end
            hist[0] <= err_r;
            hsum    <= hsum_c[HSUM_BITS-1:0];
            phase   <= P_IDLE;
          end
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

endmodule

/* dv/lcpd_drive_checker.sv */
// ---------------------------------------------------------------------------
// lcpd_drive_checker
// Watches the scan, result and register channels of the line centroid PID
// drive block, predicts each run result from its own copy of the
// calibration, setpoint, gains and error history, and compares every
// result field with the oldest prediction.
// ---------------------------------------------------------------------------
module lcpd_drive_checker #(
  parameter int SAMPLE_BITS   = 12,
  parameter int HISTORY_DEPTH = 6
) (
  input  logic                                                     clk,
  input  logic                                                     rst,
  input  logic [((lcpd_pkg::SENSOR_COUNT*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,
  input  logic [lcpd_pkg::ACTION_BITS-1:0]                         s_tuser,
  input  logic                                                     s_tvalid,
  input  logic                                                     s_tready,
  input  logic [lcpd_pkg::OUT_TDATA_BITS-1:0]                      m_tdata,
  input  logic                                                     m_tvalid,
  input  logic                                                     m_tready,
  input  logic                                                     cfg_we,
  input  logic [lcpd_pkg::CFG_INDEX_BITS-1:0]                      cfg_index,
  input  logic [lcpd_pkg::CFG_BITS-1:0]                            cfg_wdata,
  output int                                                       mismatch_total,
  output int                                                       awaiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import lcpd_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] scan_t;

  // lowest field last
  typedef struct packed {
    logic                    right_reverse;
    logic [MAG_BITS-1:0]     right_magnitude;
    logic                    left_reverse;
    logic [MAG_BITS-1:0]     left_magnitude;
    logic [SENSOR_COUNT-1:0] sensor_bits;
    logic                    line_seen;
    logic [POS_BITS-1:0]     position;
  } drive_result_t;

  int setpoint;
  int base_level;
  int kp;
  int kd;
  int ki;

  logic [SAMPLE_BITS-1:0] line_level [SENSOR_COUNT];
  logic [SAMPLE_BITS-1:0] threshold [SENSOR_COUNT];
  int                     prev_position;
  int                     error_hist [HISTORY_DEPTH];

  drive_result_t expected_drives [$];
  drive_result_t seen_drive;
  drive_result_t oldest_drive;
  scan_t         scan_in;
  int            failures;

  function automatic logic [MAG_BITS:0] drive_level(input longint level);
    logic   rev;
    longint mag;
    rev = level < 0;
    mag = rev ? -level : level;
    if (mag > PWM_PERIOD) mag = PWM_PERIOD;
    return {rev, MAG_BITS'(mag)};
  endfunction

  function automatic drive_result_t predict_scan(input scan_t scan);
    drive_result_t r;
    int            hits;
    int            wsum;
    int            pos;
    longint        err;
    longint        hsum;
    longint        term;
    r    = '0;
    hits = 0;
    wsum = 0;
    hsum = 0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (scan[i] >= threshold[i]) begin
        r.sensor_bits[i] = 1'b1;
        hits++;
        wsum += i * STEP_UNITS;
      end
    end
    if (hits != 0) pos = wsum / hits;
    else if (prev_position <= SNAP_MARGIN) pos = 0;
    else if (prev_position >= FULL_SCALE - SNAP_MARGIN) pos = FULL_SCALE;
    else pos = prev_position;
    prev_position = pos;
    err = longint'(pos) - longint'(setpoint);
    for (int i = 0; i < HISTORY_DEPTH; i++) hsum += error_hist[i];
    term = longint'(kp) * err + longint'(kd) * (err - error_hist[0])
         + longint'(ki) * hsum;
    for (int i = HISTORY_DEPTH - 1; i > 0; i--) error_hist[i] = error_hist[i-1];
    error_hist[0] = int'(err);
    r.position  = POS_BITS'(pos);
    r.line_seen = hits != 0;
    {r.left_reverse, r.left_magnitude}   = drive_level(longint'(base_level) + term);
    {r.right_reverse, r.right_magnitude} = drive_level(longint'(base_level) - term);
    return r;
  endfunction

  task automatic report_failure(input string what, input drive_result_t want,
                                input drive_result_t got);
    failures++;
    if (failures <= REPORT_LIMIT)
      $display("%0t %s: expected pos %0d seen %0d bits %h l %0d/%0d r %0d/%0d | ",
               $realtime, what, want.position, want.line_seen, want.sensor_bits,
               want.left_magnitude, want.left_reverse, want.right_magnitude,
               want.right_reverse,
               "actual pos %0d seen %0d bits %h l %0d/%0d r %0d/%0d",
               got.position, got.line_seen, got.sensor_bits, got.left_magnitude,
               got.left_reverse, got.right_magnitude, got.right_reverse);
  endtask

  initial begin
    failures       = 0;
    mismatch_total = 0;
    awaiting       = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      setpoint      = int'(TARGET_RESET);
      base_level    = int'(BASE_RESET);
      kp            = 0;
      kd            = 0;
      ki            = 0;
      prev_position = 0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        line_level[i] = '0;
        threshold[i]  = '0;
      end
      for (int i = 0; i < HISTORY_DEPTH; i++) error_hist[i] = 0;
      expected_drives.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TARGET: setpoint   = int'(cfg_wdata[POS_BITS-1:0]);
          REG_BASE:   base_level = int'(cfg_wdata[BASE_BITS-1:0]);
          REG_KP:     kp         = int'(cfg_wdata[GAIN_BITS-1:0]);
          REG_KD:     kd         = int'(cfg_wdata[GAIN_BITS-1:0]);
          REG_KI:     ki         = int'(cfg_wdata[GAIN_BITS-1:0]);
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        seen_drive = drive_result_t'(m_tdata[$bits(drive_result_t)-1:0]);
        if (expected_drives.size() == 0) begin
          report_failure("unexpected result", '0, seen_drive);
        end else begin
          oldest_drive = expected_drives.pop_front();
          if (seen_drive.position != oldest_drive.position
              || seen_drive.line_seen != oldest_drive.line_seen
              || seen_drive.sensor_bits != oldest_drive.sensor_bits
              || seen_drive.left_magnitude != oldest_drive.left_magnitude
              || seen_drive.left_reverse != oldest_drive.left_reverse
              || seen_drive.right_magnitude != oldest_drive.right_magnitude
              || seen_drive.right_reverse != oldest_drive.right_reverse)
            report_failure("result mismatch", oldest_drive, seen_drive);
        end
      end
      if (s_tvalid && s_tready) begin
        scan_in = s_tdata[SENSOR_COUNT*SAMPLE_BITS-1:0];
        case (s_tuser)
          ACT_LINE: begin
            for (int i = 0; i < SENSOR_COUNT; i++) line_level[i] = scan_in[i];
          end
          ACT_BG: begin
            for (int i = 0; i < SENSOR_COUNT; i++)
              threshold[i] = SAMPLE_BITS'((int'(line_level[i]) + int'(scan_in[i])) / 2);
          end
          ACT_RUN: expected_drives.push_back(predict_scan(scan_in));
          default: ;
        endcase
      end
    end
    awaiting       <= expected_drives.size();
    mismatch_total <= failures;
  end

endmodule

/* dv/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Drives calibration, run and ignored scans into the line centroid PID drive
// block under several register settings, with random gaps on both streams
// and one long output stall, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lcpd_pkg::*;

  localparam int SAMPLE_BITS    = 12;
  localparam int SCAN_BITS      = ((SENSOR_COUNT * SAMPLE_BITS + 7) / 8) * 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 200;
  localparam int HOLD_PHASE     = 4;
  localparam int PAUSE_PHASE    = 5;
  localparam logic [ACTION_BITS-1:0]    ACT_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE  = 3'd7;

  typedef logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] scan_t;

  logic                      clk;
  logic                      rst;
  logic [SCAN_BITS-1:0]      s_tdata;
  logic [ACTION_BITS-1:0]    s_tuser;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      m_tvalid;
  logic                      m_tready;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_wdata;

  int mismatches;
  int awaiting;
  int idle_cycles;
  int phase_num;
  bit hold_done;
  bit gapless;
  int n_line, n_bg, n_run, n_unused, n_settings;

  line_centroid_pid_drive DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lcpd_drive_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .m_tdata        (m_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_total (mismatches),
    .awaiting       (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic scan_t spot(input int first, input int width,
                                 input int hi, input int lo);
    scan_t s;
    for (int i = 0; i < SENSOR_COUNT; i++)
      s[i] = SAMPLE_BITS'((i >= first && i < first + width) ? hi : lo);
    return s;
  endfunction

  function automatic scan_t level_scan(input int lo, input int hi);
    scan_t s;
    for (int i = 0; i < SENSOR_COUNT; i++) s[i] = SAMPLE_BITS'($urandom_range(lo, hi));
    return s;
  endfunction

  function automatic scan_t line_at(input int first, input int width);
    scan_t s;
    for (int i = 0; i < SENSOR_COUNT; i++)
      s[i] = SAMPLE_BITS'((i >= first && i < first + width) ?
                          $urandom_range(2600, 4095) : $urandom_range(0, 1400));
    return s;
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CFG_BITS'($urandom_range(0, 4));
    if (r < 85) return CFG_BITS'($urandom_range(0, 32));
    return CFG_BITS'($urandom_range(0, 255));
  endfunction

  task automatic send_scan(input logic [ACTION_BITS-1:0] act, input scan_t scan);
    int gap;
    gap = gapless ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= SCAN_BITS'(scan);
    s_tuser  <= act;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    case (act)
      ACT_LINE: n_line++;
      ACT_BG:   n_bg++;
      ACT_RUN:  n_run++;
      default:  n_unused++;
    endcase
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_BITS-1:0] target,
                               input logic [CFG_BITS-1:0] base,
                               input logic [CFG_BITS-1:0] gp,
                               input logic [CFG_BITS-1:0] gd,
                               input logic [CFG_BITS-1:0] gi);
    settle();
    write_reg(REG_TARGET, target);
    write_reg(REG_BASE, base);
    write_reg(REG_KP, gp);
    write_reg(REG_KD, gd);
    write_reg(REG_KI, gi);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic calibrate();
    send_scan(ACT_LINE, level_scan(2800, 4095));
    send_scan(ACT_BG, level_scan(0, 1200));
  endtask

  // output side: random bursts and gaps, one long hold during the hold phase
  initial begin
    int burst;
    int gap;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (phase_num == HOLD_PHASE && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      burst = $urandom_range(1, 40);
      m_tready <= 1'b1;
      repeat (burst) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int r;
    rst         <= 1'b1;
    s_tdata     <= '0;
    s_tuser     <= ACT_LINE;
    s_tvalid    <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_TARGET;
    cfg_wdata   <= '0;
    idle_cycles <= 0;
    phase_num   = -1;
    hold_done   = 1'b0;
    gapless     = 1'b0;
    n_line = 0; n_bg = 0; n_run = 0; n_unused = 0; n_settings = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // zero thresholds mark every channel
    send_scan(ACT_RUN, spot(0, 0, 0, 0));
    send_scan(ACT_UNUSED, {$urandom, $urandom, $urandom});
    send_scan(ACT_LINE, spot(0, 0, 0, 4095));
    send_scan(ACT_BG, spot(0, 0, 0, 0));
    send_scan(ACT_RUN, spot(0, 1, 4095, 0));
    send_scan(ACT_RUN, spot(0, 0, 0, 0));
    send_scan(ACT_RUN, spot(7, 1, 4095, 0));
    send_scan(ACT_RUN, spot(0, 0, 0, 0));
    send_scan(ACT_RUN, spot(3, 2, 4095, 0));
    send_scan(ACT_RUN, spot(0, 0, 0, 0));
    send_scan(ACT_RUN, spot(0, 0, 0, 4095));
    // sample equal to threshold counts as marked
    send_scan(ACT_RUN, spot(2, 1, 2047, 2046));
    send_scan(ACT_RUN, spot(0, 2, 4095, 0));
    send_scan(ACT_RUN, spot(0, 0, 0, 0));
    send_scan(ACT_RUN, spot(6, 2, 4095, 0));
    send_scan(ACT_RUN, spot(0, 0, 0, 0));
    send_scan(ACT_LINE, spot(0, 0, 0, 0));
    send_scan(ACT_BG, spot(0, 0, 0, 4095));
    send_scan(ACT_LINE, spot(0, 0, 0, 4095));
    send_scan(ACT_BG, spot(0, 0, 0, 4095));
    send_scan(ACT_RUN, spot(1, 1, 4095, 4094));
    send_scan(ACT_UNUSED, spot(0, 0, 0, 4095));
    apply_setting(10'd700, 10'd100, 10'd255, 10'd255, 10'd255);
    send_scan(ACT_RUN, spot(0, 1, 4095, 0));
    send_scan(ACT_RUN, spot(7, 1, 4095, 0));

    for (int p = 0; p < PHASES; p++) begin
      gapless = (p == 2 || p == 6);
      case (p)
        0: apply_setting(10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        1: apply_setting(10'd700, 10'd100, 10'd255, 10'd255, 10'd255);
        2: apply_setting(10'd350, 10'd20, 10'd2, 10'd1, 10'd0);
        3: apply_setting(10'h3FF, 10'h3FF, pick_gain(), 10'h3FF, pick_gain());
        default: apply_setting(($urandom_range(0, 4) == 0) ? CFG_BITS'($urandom_range(0, 1023))
                                                           : CFG_BITS'($urandom_range(0, 700)),
                               CFG_BITS'($urandom_range(0, 100)),
                               pick_gain(), pick_gain(), pick_gain());
      endcase
      if (p == 3) begin
        @(posedge clk);
        write_reg(REG_SPARE, CFG_BITS'($urandom));
        cfg_we <= 1'b0;
      end
      phase_num = p;
      calibrate();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == PAUSE_PHASE && k == PHASE_ITEMS / 2) settle();
        r = $urandom_range(0, 99);
        if (r < 3)
          calibrate();
        else if (r < 11)
          send_scan(ACTION_BITS'($urandom_range(0, 3)), {$urandom, $urandom, $urandom});
        else if (r < 20)
          send_scan(ACT_RUN, level_scan(0, 1400));
        else
          send_scan(ACT_RUN, line_at($urandom_range(0, 7), $urandom_range(1, 3)));
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d scans: %0d runs, %0d line and %0d background captures, %0d unused",
             n_line + n_bg + n_run + n_unused, n_run, n_line, n_bg, n_unused);
    $display("over %0d register settings, with random stream gaps and one long output hold",
             n_settings);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
design/lcpd_pkg.sv
design/lcpd_lane.sv
design/lcpd_merge.sv
design/lcpd_pid.sv
design/line_centroid_pid_drive.sv
dv/lcpd_drive_checker.sv
dv/testbench.sv
